// ----- design/pcch_pkg.sv -----
// ----------------------------------------------------------------------------
// pcch_pkg
// Shared types and constants of the pixel colour class histogram unit.
// ----------------------------------------------------------------------------
package pcch_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int GAIN_W      = 8;
	localparam int PROD_W      = 16;
	localparam int LVL_W       = 10;
	localparam int COUNT_W     = 21;
	localparam int SUM_W       = 29;
	localparam int PCT_W       = 7;
	localparam int MEAN_W      = 8;
	localparam int DOM_W       = 4;
	localparam int NUM_CLASSES = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = QPTR_W + 1;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int FP_W        = 21;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_RED_GAIN      = 3'd0;
	localparam logic [2:0] REG_GREEN_GAIN    = 3'd1;
	localparam logic [2:0] REG_BLUE_GAIN     = 3'd2;
	localparam logic [2:0] REG_TOLERANCE_MIN = 3'd3;
	localparam logic [2:0] REG_TOLERANCE_MAX = 3'd4;
	localparam logic [2:0] REG_FRAME_PIXELS  = 3'd5;

	// Dominant class codes at the two ends of the range.
	localparam logic [DOM_W-1:0] DOM_NONE = 4'd0;
	localparam logic [DOM_W-1:0] DOM_GREY = 4'd8;

	typedef enum logic [2:0] {
		CLS_GREY   = 3'd0,
		CLS_RED    = 3'd1,
		CLS_YELLOW = 3'd2,
		CLS_GREEN  = 3'd3,
		CLS_BLUE   = 3'd4,
		CLS_PINK   = 3'd5,
		CLS_LIGHT  = 3'd6,
		CLS_DARK   = 3'd7
	} pixel_class_t;

	// One classified pixel travelling from the front to the back.
	typedef struct packed {
		logic             frame_end;
		logic [LVL_W-1:0] level;
		pixel_class_t     cls;
	} pix_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- design/pixel_colour_class_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_colour_class_histogram_unit
// Classifies RGB pixels by colour and reports per-frame class statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the pixel channel (pixel_valid / pixel_stall) with
//   red, green, blue and frame_end. Each request yields exactly one result on
//   the result channel (result_valid / result_stall) carrying pixel_class.
//   On the frame_end pixel the result also carries frame_done, the eight
//   class percentages, the dominant class and the new mean level.
//   An accepted pixel passes the three front stages and the queue before
//   its result is registered. Within a frame the unit takes one pixel per
//   cycle unless the result side stalls. A frame_end pixel holds the back
//   end for nine divisions in the shared bit-serial divider; the front
//   fills its three stages and the four-entry queue, then raises pixel_stall.
//   A stall on the result side holds the output register, fills the queue
//   and then stalls the pixel channel; nothing is dropped.
//   Reset clears the counts and the level sum, sets the previous mean to 150
//   and loads the register defaults. Registers are written over the APB port
//   at byte address 4*index and should be changed only while the unit is idle.
// ----------------------------------------------------------------------------
module pixel_colour_class_histogram_unit
	import pcch_pkg::*;
#(
	parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  logic [SAMPLE_W-1:0] red,
	input  logic [SAMPLE_W-1:0] green,
	input  logic [SAMPLE_W-1:0] blue,
	input  logic                frame_end,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [2:0]          pixel_class,
	output logic                frame_done,
	output logic [DOM_W-1:0]    dominant_class,
	output logic [PCT_W-1:0]    red_percent,
	output logic [PCT_W-1:0]    yellow_percent,
	output logic [PCT_W-1:0]    green_percent,
	output logic [PCT_W-1:0]    blue_percent,
	output logic [PCT_W-1:0]    pink_percent,
	output logic [PCT_W-1:0]    light_percent,
	output logic [PCT_W-1:0]    dark_percent,
	output logic [PCT_W-1:0]    grey_percent,
	output logic [MEAN_W-1:0]   mean_level
);

	logic [GAIN_W-1:0] red_gain_q, green_gain_q, blue_gain_q;
	logic [GAIN_W-1:0] tol_min_q, tol_max_q;
	logic [FP_W-1:0]   frame_pixels_q;
	logic              wr_en;
	logic [2:0]        reg_idx;

	logic              push, pop;
	pix_item_t         push_item, pop_item;
	q_status_t         q_status;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_gain_q     <= 8'd100;
			green_gain_q   <= 8'd100;
			blue_gain_q    <= 8'd90;
			tol_min_q      <= 8'd5;
			tol_max_q      <= 8'd30;
			frame_pixels_q <= 21'd57600;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RED_GAIN:      red_gain_q     <= pwdata[GAIN_W-1:0];
				REG_GREEN_GAIN:    green_gain_q   <= pwdata[GAIN_W-1:0];
				REG_BLUE_GAIN:     blue_gain_q    <= pwdata[GAIN_W-1:0];
				REG_TOLERANCE_MIN: tol_min_q      <= pwdata[GAIN_W-1:0];
				REG_TOLERANCE_MAX: tol_max_q      <= pwdata[GAIN_W-1:0];
				REG_FRAME_PIXELS:  frame_pixels_q <= pwdata[FP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RED_GAIN:      prdata = DATA_W'(red_gain_q);
			REG_GREEN_GAIN:    prdata = DATA_W'(green_gain_q);
			REG_BLUE_GAIN:     prdata = DATA_W'(blue_gain_q);
			REG_TOLERANCE_MIN: prdata = DATA_W'(tol_min_q);
			REG_TOLERANCE_MAX: prdata = DATA_W'(tol_max_q);
			REG_FRAME_PIXELS:  prdata = DATA_W'(frame_pixels_q);
			default:           prdata = '0;
		endcase
	end

	pcch_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_end   (frame_end),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red_gain    (red_gain_q),
		.green_gain  (green_gain_q),
		.blue_gain   (blue_gain_q),
		.push        (push),
		.push_item   (push_item),
		.q_status    (q_status)
	);

	pcch_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_status  (q_status)
	);

	pcch_back #(
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_item       (pop_item),
		.q_status       (q_status),
		.pop            (pop),
		.tolerance_min  (tol_min_q),
		.tolerance_max  (tol_max_q),
		.frame_pixels   (frame_pixels_q),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.pixel_class    (pixel_class),
		.frame_done     (frame_done),
		.dominant_class (dominant_class),
		.red_percent    (red_percent),
		.yellow_percent (yellow_percent),
		.green_percent  (green_percent),
		.blue_percent   (blue_percent),
		.pink_percent   (pink_percent),
		.light_percent  (light_percent),
		.dark_percent   (dark_percent),
		.grey_percent   (grey_percent),
		.mean_level     (mean_level)
	);

endmodule

// ----- design/pcch_front.sv -----
// ----------------------------------------------------------------------------
// pcch_front
// Accepts pixels, applies the channel gains, derives the level and runs the
// red, blue and green ratio tests. Three register stages feed the queue.
// ----------------------------------------------------------------------------
module pcch_front
	import pcch_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SAMPLE_W-1:0] red,
	input  logic [SAMPLE_W-1:0] green,
	input  logic [SAMPLE_W-1:0] blue,
	input  logic                frame_end,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  logic [GAIN_W-1:0]   red_gain,
	input  logic [GAIN_W-1:0]   green_gain,
	input  logic [GAIN_W-1:0]   blue_gain,
	output logic                push,
	output pix_item_t           push_item,
	input  q_status_t           q_status
);

	// floor(x / 100) is exact for every 16-bit x with this reciprocal.
	localparam logic [16:0] Div100Mul = 17'd83887;
	localparam int          Div100Sh  = 23;
	// floor(s / 3) is exact for every level sum up to 1950.
	localparam logic [11:0] Div3Mul   = 12'd2731;
	localparam int          Div3Sh    = 13;

	function automatic logic [LVL_W-1:0] div100(input logic [PROD_W-1:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'(Div100Mul);
		return p[Div100Sh+LVL_W-1:Div100Sh];
	endfunction

	function automatic logic [LVL_W-1:0] div3(input logic [LVL_W:0] s);
		logic [23:0] p;
		p = 24'(s) * 24'(Div3Mul);
		return p[Div3Sh+LVL_W-1:Div3Sh];
	endfunction

	logic              adv;
	logic              v_s1, v_s2, v_s3;
	logic              fe_s1, fe_s2, fe_s3;
	logic [PROD_W-1:0] rr_s1, gg_s1, bb_s1;
	logic [PROD_W-1:0] rr_s2, gg_s2, bb_s2;
	logic [PROD_W-1:0] rr_s3, gg_s3, bb_s3;
	logic [LVL_W-1:0]  sr_s2, sg_s2, sb_s2;
	logic [LVL_W-1:0]  sr_s3, sg_s3, sb_s3;
	logic [LVL_W-1:0]  lvl_s3;
	pixel_class_t      cls;

	assign pixel_stall = v_s3 && q_status.full;
	assign adv         = !pixel_stall;
	assign push        = v_s3 && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rr_s1  <= PROD_W'(red) * PROD_W'(red_gain);
			gg_s1  <= PROD_W'(green) * PROD_W'(green_gain);
			bb_s1  <= PROD_W'(blue) * PROD_W'(blue_gain);
			fe_s1  <= frame_end;

			rr_s2  <= rr_s1;
			gg_s2  <= gg_s1;
			bb_s2  <= bb_s1;
			sr_s2  <= div100(rr_s1);
			sg_s2  <= div100(gg_s1);
			sb_s2  <= div100(bb_s1);
			fe_s2  <= fe_s1;

			rr_s3  <= rr_s2;
			gg_s3  <= gg_s2;
			bb_s3  <= bb_s2;
			sr_s3  <= sr_s2;
			sg_s3  <= sg_s2;
			sb_s3  <= sb_s2;
			lvl_s3 <= div3((LVL_W+1)'(sr_s2) + (LVL_W+1)'(sg_s2) + (LVL_W+1)'(sb_s2));
			fe_s3  <= fe_s2;
		end
	end

	// Ratio tests; a later hit overrides an earlier one.
	always_comb begin
		logic [20:0] sr400, sr200, sb400, sg500, sg1000;
		logic [20:0] rr5, rr6, gg3, gg5, bb5, bb6, bb9;
		sr400  = 21'(sr_s3) * 21'd400;
		sr200  = 21'(sr_s3) * 21'd200;
		sb400  = 21'(sb_s3) * 21'd400;
		sg500  = 21'(sg_s3) * 21'd500;
		sg1000 = 21'(sg_s3) * 21'd1000;
		rr5    = 21'(rr_s3) * 21'd5;
		rr6    = 21'(rr_s3) * 21'd6;
		gg3    = 21'(gg_s3) * 21'd3;
		gg5    = 21'(gg_s3) * 21'd5;
		bb5    = 21'(bb_s3) * 21'd5;
		bb6    = 21'(bb_s3) * 21'd6;
		bb9    = 21'(bb_s3) * 21'd9;
		cls = CLS_GREY;
		if (sr_s3 > lvl_s3) begin
			if (sr400 > bb5)
				cls = (sr200 > gg3) ? CLS_RED : CLS_YELLOW;
			else if (sr200 > gg3)
				cls = CLS_PINK;
		end
		if (sb_s3 > lvl_s3) begin
			if (sb400 > gg5)
				cls = (sb400 > rr5) ? CLS_BLUE : CLS_PINK;
			else if (sb400 > rr5)
				cls = CLS_GREEN;
		end
		if (sg_s3 > lvl_s3) begin
			if (sg500 > rr6)
				cls = (sg1000 > bb9) ? CLS_GREEN : CLS_BLUE;
			else if (sg500 > bb6)
				cls = (sg_s3 > sr_s3) ? CLS_GREEN : CLS_YELLOW;
		end
	end

	assign push_item.frame_end = fe_s3;
	assign push_item.level     = lvl_s3;
	assign push_item.cls       = cls;

endmodule

// ----- design/pcch_queue.sv -----
// ----------------------------------------------------------------------------
// pcch_queue
// Small first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pcch_queue
	import pcch_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pix_item_t push_item,
	input  logic      pop,
	output pix_item_t pop_item,
	output q_status_t q_status
);

	pix_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_item       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

// ----- design/pcch_div.sv -----
// ----------------------------------------------------------------------------
// pcch_div
// Saturating restoring divider: an 8-bit quotient, one bit per cycle, after
// a first step that detects a quotient of 256 or more and returns 255.
// ----------------------------------------------------------------------------
module pcch_div
	import pcch_pkg::*;
#(
	parameter int DIVISOR_W = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SUM_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [MEAN_W-1:0]    quotient
);

	localparam int ExtW     = SUM_W + 1;
	localparam int ShW      = DIVISOR_W + MEAN_W;
	localparam int DivSteps = MEAN_W + 1;

	logic                 busy_q;
	logic [3:0]           cnt_q;
	logic [SUM_W-1:0]     rem_q;
	logic [ShW-1:0]       sd_q;
	logic                 ge;
	logic [ExtW-1:0]      diff;

	assign diff = ExtW'(rem_q) - ExtW'(sd_q);
	assign ge   = ExtW'(rem_q) >= ExtW'(sd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done     <= 1'b0;
			cnt_q    <= '0;
			quotient <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= 4'(DivSteps);
				quotient <= '0;
			end else if (busy_q) begin
				if (cnt_q == 4'(DivSteps)) begin
					// The divisor shifted up by eight still fits: saturate.
					if (ge) begin
						quotient <= '1;
						busy_q   <= 1'b0;
						done     <= 1'b1;
					end
				end else begin
					quotient <= {quotient[MEAN_W-2:0], ge};
					if (cnt_q == 4'd1) begin
						busy_q <= 1'b0;
						done   <= 1'b1;
					end
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			sd_q  <= {divisor, MEAN_W'(0)};
		end else if (busy_q) begin
			if (ge && cnt_q != 4'(DivSteps))
				rem_q <= diff[SUM_W-1:0];
			sd_q <= sd_q >> 1;
		end
	end

endmodule

// ----- design/pcch_back.sv -----
// ----------------------------------------------------------------------------
// pcch_back
// Applies the light and dark thresholds, keeps the class counts and the
// level sum, and at frame end works out the percentages and the new mean.
// ----------------------------------------------------------------------------
module pcch_back
	import pcch_pkg::*;
#(
	parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pix_item_t          pop_item,
	input  q_status_t          q_status,
	output logic               pop,
	input  logic [GAIN_W-1:0]  tolerance_min,
	input  logic [GAIN_W-1:0]  tolerance_max,
	input  logic [FP_W-1:0]    frame_pixels,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         pixel_class,
	output logic               frame_done,
	output logic [DOM_W-1:0]   dominant_class,
	output logic [PCT_W-1:0]   red_percent,
	output logic [PCT_W-1:0]   yellow_percent,
	output logic [PCT_W-1:0]   green_percent,
	output logic [PCT_W-1:0]   blue_percent,
	output logic [PCT_W-1:0]   pink_percent,
	output logic [PCT_W-1:0]   light_percent,
	output logic [PCT_W-1:0]   dark_percent,
	output logic [PCT_W-1:0]   grey_percent,
	output logic [MEAN_W-1:0]  mean_level
);

	localparam int FpBits   = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int FpW      = (FpBits < FP_W) ? FpBits : FP_W;
	localparam int MeanIdx  = NUM_CLASSES;
	localparam int ThrW     = 20;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH,
		ST_SETTLE
	} state_t;

	state_t                   state_q;
	logic [COUNT_W-1:0]       cnt_q [NUM_CLASSES];
	logic [SUM_W-1:0]         sum_q;
	logic [MEAN_W-1:0]        prev_mean_q;
	logic [3:0]               div_idx_q;
	logic [PCT_W-1:0]         pct_q [NUM_CLASSES];
	logic [PCT_W-1:0]         best_q;
	logic [DOM_W-1:0]         dom_q;
	pixel_class_t             hold_cls_q;
	logic signed [ThrW-1:0]   thr_light_q, thr_dark_q;

	logic signed [ThrW-1:0]   tmin_s, span_s, pm_s;
	logic                     out_free;
	logic                     res_load;
	logic signed [ThrW-1:0]   lvl255;
	logic                     is_light, is_dark;
	pixel_class_t             fc;
	logic [SUM_W:0]           sum_ext;
	logic [SUM_W-1:0]         sum_next;
	logic [FpW-1:0]           fp_div;
	pixel_class_t             cls_sel;
	logic [SUM_W-1:0]         dividend;
	logic                     div_start, div_done;
	logic [MEAN_W-1:0]        div_q;
	logic [PCT_W-1:0]         pct_new;

	// Threshold terms depend only on the previous mean and the tolerances.
	assign tmin_s = signed'(ThrW'(tolerance_min));
	assign span_s = signed'(ThrW'(tolerance_max)) - tmin_s;
	assign pm_s   = signed'(ThrW'(prev_mean_q));

	always_ff @(posedge clk) begin
		thr_light_q <= tmin_s * 20'sd255 + (20'sd255 - pm_s) * span_s;
		thr_dark_q  <= tmin_s * 20'sd255 + pm_s * span_s;
	end

	assign lvl255   = signed'(ThrW'(pop_item.level) * 20'd255);
	assign is_light = (lvl255 + thr_light_q) > 20'sd65025;
	assign is_dark  = lvl255 < thr_dark_q;
	assign fc       = is_light ? CLS_LIGHT : (is_dark ? CLS_DARK : pop_item.cls);

	assign sum_ext  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(pop_item.level);
	assign sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	assign out_free = !result_valid || !result_stall;
	assign pop      = (state_q == ST_RUN) && !q_status.empty && out_free;
	assign res_load = (pop && !pop_item.frame_end) || (state_q == ST_FINISH && out_free);

	always_comb begin
		if (frame_pixels == '0)
			fp_div = FpW'(1);
		else if (25'(frame_pixels) > 25'(MAX_FRAME_PIXELS))
			fp_div = FpW'(MAX_FRAME_PIXELS);
		else
			fp_div = FpW'(frame_pixels);
	end

	// Divisions run red, yellow, green, blue, pink, light, dark, grey, then
	// the mean; the index of the last class wraps to grey.
	assign cls_sel   = pixel_class_t'(div_idx_q[2:0] + 3'd1);
	assign dividend  = (div_idx_q == 4'(MeanIdx)) ? sum_q
	                                              : SUM_W'(cnt_q[cls_sel]) * SUM_W'(100);
	assign div_start = (state_q == ST_DIV_GO);
	assign pct_new   = (div_q > MEAN_W'(100)) ? PCT_W'(100) : div_q[PCT_W-1:0];

	pcch_div #(
		.DIVISOR_W (FpW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (fp_div),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_RUN;
			sum_q          <= '0;
			prev_mean_q    <= 8'd150;
			div_idx_q      <= '0;
			best_q         <= '0;
			dom_q          <= DOM_NONE;
			hold_cls_q     <= CLS_GREY;
			result_valid   <= 1'b0;
			pixel_class    <= '0;
			frame_done     <= 1'b0;
			dominant_class <= DOM_NONE;
			red_percent    <= '0;
			yellow_percent <= '0;
			green_percent  <= '0;
			blue_percent   <= '0;
			pink_percent   <= '0;
			light_percent  <= '0;
			dark_percent   <= '0;
			grey_percent   <= '0;
			mean_level     <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
				pct_q[i] <= '0;
			end
		end else begin
			if (res_load)
				result_valid <= 1'b1;
			else if (result_valid && !result_stall)
				result_valid <= 1'b0;
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						for (int i = 0; i < NUM_CLASSES; i++) begin
							if (fc == pixel_class_t'(i) && cnt_q[i] != '1)
								cnt_q[i] <= cnt_q[i] + 1'b1;
						end
						sum_q <= sum_next;
						if (pop_item.frame_end) begin
							hold_cls_q <= fc;
							div_idx_q  <= '0;
							best_q     <= '0;
							dom_q      <= DOM_NONE;
							state_q    <= ST_DIV_GO;
						end else begin
							pixel_class    <= fc;
							frame_done     <= 1'b0;
							dominant_class <= DOM_NONE;
							red_percent    <= '0;
							yellow_percent <= '0;
							green_percent  <= '0;
							blue_percent   <= '0;
							pink_percent   <= '0;
							light_percent  <= '0;
							dark_percent   <= '0;
							grey_percent   <= '0;
							mean_level     <= '0;
						end
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (div_idx_q == 4'(MeanIdx)) begin
							prev_mean_q <= div_q;
							state_q     <= ST_FINISH;
						end else begin
							pct_q[div_idx_q[2:0]] <= pct_new;
							// Strictly larger only, so the earliest class wins a tie.
							if (pct_new > best_q) begin
								best_q <= pct_new;
								dom_q  <= div_idx_q + 1'b1;
							end
							div_idx_q <= div_idx_q + 1'b1;
							state_q   <= ST_DIV_GO;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						pixel_class    <= hold_cls_q;
						frame_done     <= 1'b1;
						dominant_class <= dom_q;
						red_percent    <= pct_q[0];
						yellow_percent <= pct_q[1];
						green_percent  <= pct_q[2];
						blue_percent   <= pct_q[3];
						pink_percent   <= pct_q[4];
						light_percent  <= pct_q[5];
						dark_percent   <= pct_q[6];
						grey_percent   <= pct_q[7];
						mean_level     <= prev_mean_q;
						sum_q          <= '0;
						for (int i = 0; i < NUM_CLASSES; i++)
							cnt_q[i] <= '0;
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					// Lets the thresholds follow the new mean before the next pixel.
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

// ----- design/pcch_checker.sv -----
// ----------------------------------------------------------------------------
// pcch_checker
// Port-level checks on the result channel of the histogram unit.
// ----------------------------------------------------------------------------
module pcch_checker
	import pcch_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input logic [2:0]        pixel_class,
	input logic              frame_done,
	input logic [DOM_W-1:0]  dominant_class,
	input logic [PCT_W-1:0]  red_percent,
	input logic [PCT_W-1:0]  yellow_percent,
	input logic [PCT_W-1:0]  green_percent,
	input logic [PCT_W-1:0]  blue_percent,
	input logic [PCT_W-1:0]  pink_percent,
	input logic [PCT_W-1:0]  light_percent,
	input logic [PCT_W-1:0]  dark_percent,
	input logic [PCT_W-1:0]  grey_percent,
	input logic [MEAN_W-1:0] mean_level
);

	logic all_zero_pct;

	assign all_zero_pct = red_percent == '0 && yellow_percent == '0 &&
	                      green_percent == '0 && blue_percent == '0 &&
	                      pink_percent == '0 && light_percent == '0 &&
	                      dark_percent == '0 && grey_percent == '0;

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(pixel_class) && $stable(frame_done) &&
			$stable(mean_level) && $stable(dominant_class))
		else $error("stalled result changed");

	// Summary fields are zero on ordinary pixels.
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !frame_done |->
			all_zero_pct && dominant_class == DOM_NONE && mean_level == '0)
		else $error("summary fields set without frame_done");

	// Percentages saturate at 100 and the dominant code stays in range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |->
			red_percent <= 7'd100 && yellow_percent <= 7'd100 &&
			green_percent <= 7'd100 && blue_percent <= 7'd100 &&
			pink_percent <= 7'd100 && light_percent <= 7'd100 &&
			dark_percent <= 7'd100 && grey_percent <= 7'd100 &&
			dominant_class <= DOM_GREY)
		else $error("frame summary out of range");

	// No dominant class only when every share rounds to zero.
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done && dominant_class == DOM_NONE |-> all_zero_pct)
		else $error("no dominant class despite a nonzero share");

endmodule

bind pixel_colour_class_histogram_unit pcch_checker u_pcch_checker (.*);

// ----- sim/pixel_colour_class_histogram_unit_checker.sv -----
// ----------------------------------------------------------------------------
// pixel_colour_class_histogram_unit_checker
// Watches the register port and both channels of the histogram unit. It keeps
// its own copy of the settings, class counts, level sum and previous mean,
// predicts one report per accepted pixel and compares every accepted result,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_colour_class_histogram_unit_checker
	import pcch_pkg::*;
#(
	parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                pixel_valid,
	input  logic                pixel_stall,
	input  logic [SAMPLE_W-1:0] red,
	input  logic [SAMPLE_W-1:0] green,
	input  logic [SAMPLE_W-1:0] blue,
	input  logic                frame_end,
	input  logic                result_valid,
	input  logic                result_stall,
	input  logic [2:0]          pixel_class,
	input  logic                frame_done,
	input  logic [DOM_W-1:0]    dominant_class,
	input  logic [PCT_W-1:0]    red_percent,
	input  logic [PCT_W-1:0]    yellow_percent,
	input  logic [PCT_W-1:0]    green_percent,
	input  logic [PCT_W-1:0]    blue_percent,
	input  logic [PCT_W-1:0]    pink_percent,
	input  logic [PCT_W-1:0]    light_percent,
	input  logic [PCT_W-1:0]    dark_percent,
	input  logic [PCT_W-1:0]    grey_percent,
	input  logic [MEAN_W-1:0]   mean_level,
	output int                  error_count,
	output int                  outstanding
);

	localparam int MAX_PRINTED = 200;
	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
	localparam logic [SUM_W-1:0]   SUM_SAT   = '1;

	// Percentages are held in port order: red, yellow, green, blue, pink,
	// light, dark, grey.
	typedef struct packed {
		pixel_class_t                      cls;
		logic                              done;
		logic [DOM_W-1:0]                  dom;
		logic [NUM_CLASSES-1:0][PCT_W-1:0] pct;
		logic [MEAN_W-1:0]                 mean;
	} pixel_report_t;

	logic [GAIN_W-1:0]  gain_r, gain_g, gain_b, tol_lo, tol_hi;
	logic [FP_W-1:0]    frame_len;
	logic [MEAN_W-1:0]  last_mean;
	logic [COUNT_W-1:0] class_tally [NUM_CLASSES];
	logic [SUM_W-1:0]   level_total;
	pixel_report_t      pending_reports [$];

	task automatic flag_error(input string msg);
		if (error_count < MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input longint got, input longint want);
		if (got != want)
			flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Products are channel times gain; the ratio tests compare a scaled
	// channel, the product floored over 100, against an unscaled product.
	function automatic pixel_class_t sort_pixel(input longint pr, input longint pg,
			input longint pb, input longint lvl);
		longint sr, sg, sb, lo, span, pm;
		pixel_class_t c;
		sr = pr / 100;
		sg = pg / 100;
		sb = pb / 100;
		lo = longint'(tol_lo);
		span = longint'(tol_hi) - lo;
		pm = longint'(last_mean);
		c = CLS_GREY;
		if (255 * lvl + 255 * lo + (255 - pm) * span > 65025)
			return CLS_LIGHT;
		if (255 * lvl < 255 * lo + pm * span)
			return CLS_DARK;
		if (sr > lvl) begin
			if (400 * sr > 5 * pb)
				c = (200 * sr > 3 * pg) ? CLS_RED : CLS_YELLOW;
			else if (200 * sr > 3 * pg)
				c = CLS_PINK;
		end
		if (sb > lvl) begin
			if (400 * sb > 5 * pg)
				c = (400 * sb > 5 * pr) ? CLS_BLUE : CLS_PINK;
			else if (400 * sb > 5 * pr)
				c = CLS_GREEN;
		end
		if (sg > lvl) begin
			if (500 * sg > 6 * pr)
				c = (1000 * sg > 9 * pb) ? CLS_GREEN : CLS_BLUE;
			else if (500 * sg > 6 * pb)
				c = (sg > sr) ? CLS_GREEN : CLS_YELLOW;
		end
		return c;
	endfunction

	task automatic predict_pixel_report(input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
			input logic [SAMPLE_W-1:0] b, input logic fe);
		longint pr, pg, pb, lvl, fp, p, best, avg;
		pixel_class_t c;
		pixel_report_t rep;
		int k, code;
		pr = longint'(r) * longint'(gain_r);
		pg = longint'(g) * longint'(gain_g);
		pb = longint'(b) * longint'(gain_b);
		lvl = (pr / 100 + pg / 100 + pb / 100) / 3;
		c = sort_pixel(pr, pg, pb, lvl);
		rep = '0;
		rep.cls = c;
		if (class_tally[c] != COUNT_SAT)
			class_tally[c] = class_tally[c] + 1'b1;
		if (longint'(SUM_SAT) - longint'(level_total) < lvl)
			level_total = SUM_SAT;
		else
			level_total = SUM_W'(longint'(level_total) + lvl);
		if (fe) begin
			fp = (frame_len == '0) ? 1 : longint'(frame_len);
			if (fp > MAX_FRAME_PIXELS)
				fp = MAX_FRAME_PIXELS;
			best = 0;
			for (k = 0; k < NUM_CLASSES; k++) begin
				// Grey is code 0 but comes last in the port order.
				code = (k + 1) % NUM_CLASSES;
				p = (100 * longint'(class_tally[code])) / fp;
				if (p > 100)
					p = 100;
				rep.pct[k] = PCT_W'(p);
				if (p > best) begin
					best = p;
					rep.dom = DOM_W'(k + 1);
				end
			end
			avg = longint'(level_total) / fp;
			if (avg > 255)
				avg = 255;
			rep.done = 1'b1;
			rep.mean = MEAN_W'(avg);
			last_mean = MEAN_W'(avg);
			foreach (class_tally[j])
				class_tally[j] = '0;
			level_total = '0;
		end
		pending_reports.push_back(rep);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_report_t want;
		if (!arst_n) begin
			gain_r = 8'd100;
			gain_g = 8'd100;
			gain_b = 8'd90;
			tol_lo = 8'd5;
			tol_hi = 8'd30;
			frame_len = FP_W'(57600);
			last_mean = 8'd150;
			foreach (class_tally[j])
				class_tally[j] = '0;
			level_total = '0;
			pending_reports.delete();
			error_count = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_RED_GAIN:      gain_r = pwdata[GAIN_W-1:0];
					REG_GREEN_GAIN:    gain_g = pwdata[GAIN_W-1:0];
					REG_BLUE_GAIN:     gain_b = pwdata[GAIN_W-1:0];
					REG_TOLERANCE_MIN: tol_lo = pwdata[GAIN_W-1:0];
					REG_TOLERANCE_MAX: tol_hi = pwdata[GAIN_W-1:0];
					REG_FRAME_PIXELS:  frame_len = pwdata[FP_W-1:0];
					default: ;
				endcase
			end
			// A result can never belong to the request taken at the same edge.
			if (result_valid && !result_stall) begin
				if (pending_reports.size() == 0) begin
					flag_error("result with no pixel request waiting for it");
				end else begin
					want = pending_reports.pop_front();
					compare_field("pixel_class", pixel_class, want.cls);
					compare_field("frame_done", frame_done, want.done);
					compare_field("dominant_class", dominant_class, want.dom);
					compare_field("red_percent", red_percent, want.pct[0]);
					compare_field("yellow_percent", yellow_percent, want.pct[1]);
					compare_field("green_percent", green_percent, want.pct[2]);
					compare_field("blue_percent", blue_percent, want.pct[3]);
					compare_field("pink_percent", pink_percent, want.pct[4]);
					compare_field("light_percent", light_percent, want.pct[5]);
					compare_field("dark_percent", dark_percent, want.pct[6]);
					compare_field("grey_percent", grey_percent, want.pct[7]);
					compare_field("mean_level", mean_level, want.mean);
				end
			end
			if (pixel_valid && !pixel_stall)
				predict_pixel_report(red, green, blue, frame_end);
			outstanding <= pending_reports.size();
		end
	end

endmodule

// ----- sim/pixel_colour_class_histogram_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pixel_colour_class_histogram_unit_tb
// Drives pixel frames and register settings into the histogram unit, with
// random idling on both channels and one long result hold-off, and leaves
// prediction and comparison to the checker beside the unit.
// ----------------------------------------------------------------------------
module pixel_colour_class_histogram_unit_tb;
	import pcch_pkg::*;

	localparam int unsigned MAX_PIX = 1048576;
	localparam int IDLE_LIMIT      = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TARGET_PIXELS   = 1050;
	localparam int DRAIN_CYCLES    = 20;

	// Addresses past the register list, which the unit must ignore.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                pixel_valid;
	logic                pixel_stall;
	logic [SAMPLE_W-1:0] red;
	logic [SAMPLE_W-1:0] green;
	logic [SAMPLE_W-1:0] blue;
	logic                frame_end;
	logic                result_valid;
	logic                result_stall;
	logic [2:0]          pixel_class;
	logic                frame_done;
	logic [DOM_W-1:0]    dominant_class;
	logic [PCT_W-1:0]    red_percent;
	logic [PCT_W-1:0]    yellow_percent;
	logic [PCT_W-1:0]    green_percent;
	logic [PCT_W-1:0]    blue_percent;
	logic [PCT_W-1:0]    pink_percent;
	logic [PCT_W-1:0]    light_percent;
	logic [PCT_W-1:0]    dark_percent;
	logic [PCT_W-1:0]    grey_percent;
	logic [MEAN_W-1:0]   mean_level;

	int error_count;
	int outstanding;
	int pixels_sent   = 0;
	int idle_cycles   = 0;
	bit calm          = 1'b0;
	bit hold_off_req  = 1'b0;

	pixel_colour_class_histogram_unit #(
		.MAX_FRAME_PIXELS(MAX_PIX)
	) uut (.*);

	pixel_colour_class_histogram_unit_checker #(
		.MAX_FRAME_PIXELS(MAX_PIX)
	) histogram_check (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
				(psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int burst;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 16);
				result_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [2:0] index, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Starts and ends at a falling edge; valid stays high after the request
	// is taken so that back-to-back requests need no extra edge.
	task automatic send_pixel(input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
			input logic [SAMPLE_W-1:0] b, input logic fe);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		frame_end <= fe;
		do @(posedge clk); while (pixel_stall);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic drain_results();
		pixel_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return GAIN_W'($urandom_range(50, 160));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_tolerance();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return GAIN_W'($urandom_range(0, 40));
		endcase
	endfunction

	task automatic configure_phase();
		logic [DATA_W-1:0] junk;
		logic [DATA_W-1:0] fp;
		junk = $urandom() & 32'hFFFF_FF00;
		write_reg(REG_RED_GAIN, junk | DATA_W'(pick_gain()));
		write_reg(REG_GREEN_GAIN, junk | DATA_W'(pick_gain()));
		write_reg(REG_BLUE_GAIN, junk | DATA_W'(pick_gain()));
		write_reg(REG_TOLERANCE_MIN, junk | DATA_W'(pick_tolerance()));
		write_reg(REG_TOLERANCE_MAX, junk | DATA_W'(pick_tolerance()));
		case ($urandom_range(0, 15))
			0: fp = '0;
			1: fp = MAX_PIX;
			2: fp = '1;
			3: fp = 1;
			default: fp = $urandom_range(2, 48);
		endcase
		write_reg(REG_FRAME_PIXELS, fp);
	endtask

	task automatic send_frame(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_pixel(rand_sample(), rand_sample(), rand_sample(), i == len - 1);
	endtask

	initial begin : stimulus
		int phase, frame_idx, stop_at, len;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		frame_end = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// One pixel of every class under the reset settings; the frame is far
		// shorter than its nominal size, so every percentage comes out zero.
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd255, 1'b1);

		// More pixels than the frame size: percentage and mean both saturate.
		drain_results();
		write_reg(REG_FRAME_PIXELS, 4);
		repeat (5) send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

		// A zero frame size divides as one.
		drain_results();
		write_reg(REG_FRAME_PIXELS, 0);
		send_pixel(8'd200, 8'd40, 8'd90, 1'b1);

		// A frame size above the maximum is clamped, so nothing reaches one
		// percent and no class dominates.
		drain_results();
		write_reg(REG_FRAME_PIXELS, '1);
		send_pixel(8'd10, 8'd200, 8'd30, 1'b0);
		send_pixel(8'd90, 8'd60, 8'd250, 1'b1);

		// Writes past the register list change nothing; then a tie between
		// red and green, which red wins.
		drain_results();
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		write_reg(REG_FRAME_PIXELS, 2);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b1);

		phase = 0;
		while (pixels_sent < TARGET_PIXELS) begin
			drain_results();
			configure_phase();
			calm = (pixels_sent > TARGET_PIXELS - 150) || ($urandom_range(0, 3) == 0);
			stop_at = pixels_sent + $urandom_range(40, 120);
			frame_idx = 0;
			while (pixels_sent < stop_at) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 60)
					: $urandom_range(1, 24);
				// Hold the result side off while requests keep coming, so
				// the unit fills up and stalls its input.
				if (phase == 2 && frame_idx == 0)
					hold_off_req = 1'b1;
				send_frame(len);
				// Pause mid-phase until every result is back.
				if (phase == 4 && frame_idx == 0)
					drain_results();
				frame_idx++;
			end
			phase++;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
